### design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, widths and helpers shared by the box/plane contact generator.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int ROT_BITS = 14;
  localparam int PROD_W   = 48;  // rotation entry x signed offset
  localparam int VERT_W   = 37;  // corner position
  localparam int NPROD_W  = 53;  // corner x normal
  localparam int DIST_W   = 41;
  localparam int PEN_W    = 42;
  localparam int QPROD_W  = 58;  // normal x penetration
  localparam int CONT_W   = 45;  // contact before saturation

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [3:0]           limit;
    logic [2:0][2:0][15:0] rot;   // rot[row][col]
    logic [2:0][30:0]     half;
    logic [2:0][31:0]     ctr;
  } box_t;

  typedef struct packed {
    logic [2:0] corner;
    logic [3:0] limit;
  } tag_t;

  typedef struct packed {
    logic [2:0][15:0] nrm;
    logic [31:0]      offset;
  } plane_t;

  typedef struct packed {
    logic [2:0]       corner;
    logic [30:0]      pen;
    logic [2:0][31:0] pos;
  } contact_t;

  function automatic logic [31:0] sat_s32(input logic signed [CONT_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(CONT_W'(32'sh7FFF_FFFF))) r = 32'h7FFF_FFFF;
    else if (v < -$signed(CONT_W'(33'sh0_8000_0000))) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### design/bpc_seq.sv
// ----------------------------------------------------------------------------
// bpc_seq
// Takes one box and issues its eight corners, one per cycle while en is high.
// ----------------------------------------------------------------------------
module bpc_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  output logic          in_ready,
  input  bpc_pkg::box_t in_box,
  output logic          tok_valid,
  output bpc_pkg::box_t tok_box,
  output bpc_pkg::tag_t tok_tag
);

  logic       busy;
  logic [2:0] cnt;
  logic       accept;

  assign in_ready = en && (!busy || cnt == 3'd7);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (en && busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) tok_box <= in_box;
  end

  assign tok_valid      = busy;
  assign tok_tag.corner = cnt;
  assign tok_tag.limit  = tok_box.limit;

endmodule

### design/bpc_corner.sv
// ----------------------------------------------------------------------------
// bpc_corner
// Rotates the signed half extents and adds the centre (two stages).
// ----------------------------------------------------------------------------
module bpc_corner (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          tok_valid,
  input  bpc_pkg::box_t tok_box,
  input  bpc_pkg::tag_t tok_tag,
  output logic          v_valid,
  output logic [2:0][bpc_pkg::VERT_W-1:0] v_vert,
  output bpc_pkg::tag_t v_tag
);

  logic [2:0][31:0]  off;
  logic [2:0][2:0][bpc_pkg::PROD_W-1:0] prod;
  logic [2:0][31:0]  a_ctr;
  bpc_pkg::tag_t     a_tag;
  logic              a_valid;
  logic [2:0][bpc_pkg::VERT_W-1:0] vert_next;

  // corner bit 2 picks x, bit 1 y, bit 0 z; set means plus side
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      off[j] = tok_tag.corner[2-j] ? {1'b0, tok_box.half[j]}
                                   : 32'(-$signed({1'b0, tok_box.half[j]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      v_valid <= 1'b0;
    end else if (en) begin
      a_valid <= tok_valid;
      v_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= bpc_pkg::PROD_W'($signed(tok_box.rot[i][j]) * $signed(off[j]));
        end
      end
      a_ctr <= tok_box.ctr;
      a_tag <= tok_tag;
      v_vert <= vert_next;
      v_tag  <= a_tag;
    end
  end

  always_comb begin
    logic signed [bpc_pkg::PROD_W+1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = $signed({{2{prod[i][0][bpc_pkg::PROD_W-1]}}, prod[i][0]})
          + $signed({{2{prod[i][1][bpc_pkg::PROD_W-1]}}, prod[i][1]})
          + $signed({{2{prod[i][2][bpc_pkg::PROD_W-1]}}, prod[i][2]});
      // floor shift: drop the low bits of the two's complement sum
      vert_next[i] = bpc_pkg::VERT_W'($signed(acc[bpc_pkg::PROD_W+1:bpc_pkg::ROT_BITS]))
                   + bpc_pkg::VERT_W'($signed(a_ctr[i]));
    end
  end

endmodule

### design/bpc_plane.sv
// ----------------------------------------------------------------------------
// bpc_plane
// Distance along the normal, contact test and push (three stages).
// ----------------------------------------------------------------------------
module bpc_plane (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bpc_pkg::plane_t plane,
  input  logic            v_valid,
  input  logic [2:0][bpc_pkg::VERT_W-1:0] v_vert,
  input  bpc_pkg::tag_t   v_tag,
  output logic            h_valid,
  output logic            h_hit,
  output logic [bpc_pkg::PEN_W-1:0] h_pen,
  output logic [2:0][bpc_pkg::QPROD_W-1:0] h_q,
  output logic [2:0][bpc_pkg::VERT_W-1:0] h_vert,
  output bpc_pkg::tag_t   h_tag
);

  logic                 c_valid, d_valid;
  logic [2:0][bpc_pkg::NPROD_W-1:0] c_p;
  logic [2:0][bpc_pkg::VERT_W-1:0]  c_vert, d_vert;
  bpc_pkg::tag_t        c_tag, d_tag;
  logic                 d_hit;
  logic [bpc_pkg::PEN_W-1:0] d_pen;
  logic signed [bpc_pkg::NPROD_W+1:0] dsum;
  logic signed [bpc_pkg::DIST_W-1:0]  height;
  logic signed [bpc_pkg::PEN_W-1:0]   offs;

  always_comb begin
    dsum = $signed({{2{c_p[0][bpc_pkg::NPROD_W-1]}}, c_p[0]})
         + $signed({{2{c_p[1][bpc_pkg::NPROD_W-1]}}, c_p[1]})
         + $signed({{2{c_p[2][bpc_pkg::NPROD_W-1]}}, c_p[2]});
    height = dsum[bpc_pkg::NPROD_W+1:bpc_pkg::ROT_BITS];
    offs = bpc_pkg::PEN_W'($signed(plane.offset));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      h_valid <= 1'b0;
    end else if (en) begin
      c_valid <= v_valid;
      d_valid <= c_valid;
      h_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_p[i] <= bpc_pkg::NPROD_W'($signed(v_vert[i]) * $signed(plane.nrm[i]));
      end
      c_vert <= v_vert;
      c_tag  <= v_tag;
      d_hit  <= bpc_pkg::PEN_W'(height) <= offs;
      d_pen  <= offs - bpc_pkg::PEN_W'(height);
      d_vert <= c_vert;
      d_tag  <= c_tag;
      for (int i = 0; i < 3; i++) begin
        h_q[i] <= bpc_pkg::QPROD_W'($signed(plane.nrm[i]) * $signed(d_pen));
      end
      h_hit  <= d_hit;
      h_pen  <= d_pen;
      h_vert <= d_vert;
      h_tag  <= d_tag;
    end
  end

endmodule

### design/bpc_emit.sv
// ----------------------------------------------------------------------------
// bpc_emit
// Saturates each contact, applies the per-box limit, marks the last word.
// ----------------------------------------------------------------------------
module bpc_emit (
  input  logic          clk,
  input  logic          rst,
  output logic          en,
  input  logic          h_valid,
  input  logic          h_hit,
  input  logic [bpc_pkg::PEN_W-1:0] h_pen,
  input  logic [2:0][bpc_pkg::QPROD_W-1:0] h_q,
  input  logic [2:0][bpc_pkg::VERT_W-1:0] h_vert,
  input  bpc_pkg::tag_t h_tag,
  output logic          out_valid,
  input  logic          out_ready,
  output bpc_pkg::contact_t out_word,
  output logic          out_last
);

  bpc_pkg::contact_t cur, pend;
  logic        pend_valid, pend_final;
  logic [3:0]  found, base;
  logic        counted, emit, emit_last, cur_final;

  assign en = !out_valid || out_ready;

  always_comb begin
    logic signed [bpc_pkg::CONT_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = bpc_pkg::CONT_W'($signed(h_vert[i]))
          + bpc_pkg::CONT_W'($signed(h_q[i][bpc_pkg::QPROD_W-1:bpc_pkg::ROT_BITS]));
      cur.pos[i] = bpc_pkg::sat_s32(sum);
    end
    cur.pen    = (h_pen[bpc_pkg::PEN_W-1:31] != '0) ? 31'h7FFF_FFFF : h_pen[30:0];
    cur.corner = h_tag.corner;

    base      = (h_tag.corner == 3'd0) ? 4'd0 : found;
    counted   = h_valid && h_hit && (base < h_tag.limit);
    cur_final = (h_tag.corner == 3'd7) || (base + 4'd1 == h_tag.limit);
    // release the held word once its successor, or the end of its box, is known
    emit      = pend_valid && (pend_final || (h_valid && (counted || h_tag.corner == 3'd7)));
    emit_last = pend_final || !counted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      pend_final <= 1'b0;
      found      <= '0;
    end else if (en) begin
      out_valid <= emit;
      if (h_valid) found <= base + (counted ? 4'd1 : 4'd0);
      if (counted) begin
        pend_valid <= 1'b1;
        pend_final <= cur_final;
      end else if (emit) begin
        pend_valid <= 1'b0;
        pend_final <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (counted) pend <= cur;
      if (emit) begin
        out_word <= pend;
        out_last <= emit_last;
      end
    end
  end

endmodule

### design/box_plane_contact_generator.sv
// A touching corner's word is held until the next touching corner of its box reaches the
// emit stage, or until the box's last corner passes when no later corner touches; the box's
// final word leaves without waiting.
// The corner sequencer issues one corner per cycle, unless the output stalls, into a
// seven-stage pipeline, and takes the next box as it issues the last corner.
// Reset (rst, synchronous): empties pipeline, held word and output; plane (0, 1.0, 0), 0.
// ----------------------------------------------------------------------------
// box_plane_contact_generator
// Box-versus-plane vertex contacts, one corner per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module box_plane_contact_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z,
  // rot_row0, rot_row1, rot_row2, contact_limit, zero fill
  input  logic [343:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // contact_x, contact_y, contact_z, penetration, corner_index, zero fill
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  bpc_pkg::plane_t   plane;
  bpc_pkg::box_t     in_box, tok_box;
  bpc_pkg::tag_t     tok_tag, v_tag, h_tag;
  logic              en, tok_valid, v_valid, h_valid, h_hit;
  logic [2:0][bpc_pkg::VERT_W-1:0]  v_vert, h_vert;
  logic [bpc_pkg::PEN_W-1:0]        h_pen;
  logic [2:0][bpc_pkg::QPROD_W-1:0] h_q;
  bpc_pkg::contact_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane.nrm    <= {16'd0, 16'd16384, 16'd0};
      plane.offset <= '0;
    end else if (cfg_we) begin
      unique case (bpc_pkg::reg_index_t'(cfg_index))
        bpc_pkg::REG_NORMAL_X:     plane.nrm[0] <= cfg_data[15:0];
        bpc_pkg::REG_NORMAL_Y:     plane.nrm[1] <= cfg_data[15:0];
        bpc_pkg::REG_NORMAL_Z:     plane.nrm[2] <= cfg_data[15:0];
        bpc_pkg::REG_PLANE_OFFSET: plane.offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_box.ctr[i]  = s_axis_tdata[32*i +: 32];
      in_box.half[i] = s_axis_tdata[96 + 31*i +: 31];
      for (int j = 0; j < 3; j++) begin
        in_box.rot[i][j] = s_axis_tdata[189 + 48*i + 16*j +: 16];
      end
    end
    in_box.limit = s_axis_tdata[336:333];
  end

  bpc_seq u_seq (
    .clk, .rst, .en,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_box,
    .tok_valid, .tok_box, .tok_tag
  );

  bpc_corner u_corner (
    .clk, .rst, .en,
    .tok_valid, .tok_box, .tok_tag,
    .v_valid, .v_vert, .v_tag
  );

  bpc_plane u_plane (
    .clk, .rst, .en, .plane,
    .v_valid, .v_vert, .v_tag,
    .h_valid, .h_hit, .h_pen, .h_q, .h_vert, .h_tag
  );

  bpc_emit u_emit (
    .clk, .rst, .en,
    .h_valid, .h_hit, .h_pen, .h_q, .h_vert, .h_tag,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word,
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_word.corner, out_word.pen,
                         out_word.pos[2], out_word.pos[1], out_word.pos[0]};

endmodule

### design/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the contact generator, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // a stalled output freezes intake
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // a box holds the sequencer until its last corner is issued
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("box taken on consecutive cycles");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind box_plane_contact_generator bpc_checker u_bpc_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
